// ----- hw/rtl/tcce_pkg.sv -----
// Shared types and constants for the text console character engine.
package tcce_pkg;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned ATTR_W     = 8;
  localparam int unsigned INDEX_W    = 11;
  localparam int unsigned CELL_W     = 16;
  localparam int unsigned COL_OUT_W  = 7;
  localparam int unsigned LINE_OUT_W = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CODE_BLANK = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  localparam int unsigned TAB_STEP = 8;
  localparam int unsigned TAB_LOW  = 7;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] code;
  } cell_t;

endpackage

// ----- hw/rtl/tcce_cell_ram.sv -----
// Cell store memory with one write port and one registered read port.
module tcce_cell_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  tcce_pkg::cell_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output tcce_pkg::cell_t rdata_o
);
  import tcce_pkg::*;

  cell_t mem_q [DEPTH];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/text_console_character_engine_unit.sv -----
// Text console engine: cursor control and sequencing around the cell store.
// A put passes through ST_PUT, a read through ST_RD_ISSUE and ST_RD_DATA; busy stays high until ST_IDLE.
// A put that scrolls copies each row up one row through the store's read and write ports, then blanks the bottom row.
// A clear blanks every cell and homes the cursor. Each result is strobed one cycle on done_o, never held.
// After reset the store is swept to blank while busy is high.
module text_console_character_engine_unit #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [tcce_pkg::KIND_W-1:0]     kind_i,
  input  logic [tcce_pkg::CHAR_W-1:0]     char_code_i,
  input  logic [tcce_pkg::INDEX_W-1:0]    cell_index_i,
  input  logic [tcce_pkg::ATTR_W-1:0]     clear_attr_i,
  output logic                            done_o,
  output logic [tcce_pkg::CELL_W-1:0]     cell_data_o,
  output logic [tcce_pkg::COL_OUT_W-1:0]  cursor_column_o,
  output logic [tcce_pkg::LINE_OUT_W-1:0] cursor_line_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tcce_pkg::ATTR_W-1:0]     cfg_data_i
);
  import tcce_pkg::*;

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned LW    = $clog2(ROWS);

  localparam logic [AW-1:0] LAST_ADDR   = AW'(CELLS - 1);
  localparam logic [AW-1:0] BOTTOM_BASE = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
  localparam logic [CW:0]   COLS_X      = (CW+1)'(COLUMNS);
  localparam logic [LW-1:0] LAST_LINE   = LW'(ROWS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_SC_COPY,
    ST_SC_LAST,
    ST_FILL
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       fill_addr_q, fill_addr_d;
  cell_t               fill_val_q, fill_val_d;
  logic                fill_report_q, fill_report_d;
  logic [AW-1:0]       src_q, src_d;
  logic                cp_pend_q, cp_pend_d;
  logic [AW-1:0]       cp_addr_q, cp_addr_d;
  logic [CW-1:0]       col_q, col_d;
  logic [LW-1:0]       line_q, line_d;
  logic [ATTR_W-1:0]   attr_q, attr_d;
  logic                done_q, done_d;
  logic [CELL_W-1:0]   data_q, data_d;
  logic [CHAR_W-1:0]   code_q, code_d;
  logic [INDEX_W-1:0]  index_q, index_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  cell_t               ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  cell_t               ram_rdata;

  logic [CW:0]         col_x;
  logic                line_step;
  logic                put_write;

  tcce_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    col_x     = {1'b0, col_q};
    line_step = 1'b0;
    put_write = 1'b0;
    case (code_q)
      CODE_LF: begin
        col_x     = '0;
        line_step = 1'b1;
      end
      CODE_CR: begin
        col_x = '0;
      end
      CODE_TAB: begin
        col_x = ({1'b0, col_q} + (CW+1)'(TAB_STEP)) & ~((CW+1)'(TAB_LOW));
      end
      CODE_BS: begin
        if (col_q != '0) begin
          col_x = {1'b0, col_q} - (CW+1)'(1);
        end
      end
      default: begin
        put_write = 1'b1;
        col_x     = {1'b0, col_q} + (CW+1)'(1);
      end
    endcase
    if (col_x >= COLS_X) begin
      col_x     = '0;
      line_step = 1'b1;
    end
  end

  always_comb begin
    state_d       = state_q;
    fill_addr_d   = fill_addr_q;
    fill_val_d    = fill_val_q;
    fill_report_d = fill_report_q;
    src_d         = src_q;
    cp_pend_d     = 1'b0;
    cp_addr_d     = cp_addr_q;
    col_d         = col_q;
    line_d        = line_q;
    attr_d        = cfg_valid_i ? cfg_data_i : attr_q;
    done_d        = 1'b0;
    data_d        = data_q;
    code_d        = code_q;
    index_d       = index_q;
    ram_we        = 1'b0;
    ram_waddr     = fill_addr_q;
    ram_wdata     = fill_val_q;
    ram_re        = 1'b0;
    ram_raddr     = src_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          code_d  = char_code_i;
          index_d = cell_index_i;
          case (kind_i)
            KIND_PUT: begin
              state_d = ST_PUT;
            end
            KIND_READ: begin
              state_d = ST_RD_ISSUE;
            end
            KIND_CLEAR: begin
              fill_addr_d   = '0;
              fill_val_d    = {clear_attr_i, CODE_BLANK};
              fill_report_d = 1'b1;
              col_d         = '0;
              line_d        = '0;
              state_d       = ST_FILL;
            end
            default: begin
              done_d = 1'b1;
              data_d = '0;
            end
          endcase
        end
      end
      ST_PUT: begin
        ram_we    = put_write;
        ram_waddr = AW'(line_q) * COLS_A + AW'(col_q);
        ram_wdata = {attr_q, code_q};
        col_d     = col_x[CW-1:0];
        data_d    = '0;
        if (line_step && (line_q == LAST_LINE)) begin
          src_d   = COLS_A;
          state_d = ST_SC_COPY;
        end else begin
          if (line_step) begin
            line_d = line_q + LW'(1);
          end
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_RD_ISSUE: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(index_q);
        state_d   = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        data_d  = (32'(index_q) < CELLS) ? ram_rdata : '0;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SC_COPY: begin
        ram_re    = 1'b1;
        ram_raddr = src_q;
        cp_pend_d = 1'b1;
        cp_addr_d = src_q - COLS_A;
        if (cp_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = cp_addr_q;
          ram_wdata = ram_rdata;
        end
        if (src_q == LAST_ADDR) begin
          state_d = ST_SC_LAST;
        end else begin
          src_d = src_q + AW'(1);
        end
      end
      ST_SC_LAST: begin
        ram_we        = 1'b1;
        ram_waddr     = cp_addr_q;
        ram_wdata     = ram_rdata;
        fill_addr_d   = BOTTOM_BASE;
        fill_val_d    = {attr_q, CODE_BLANK};
        fill_report_d = 1'b1;
        state_d       = ST_FILL;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_addr_q;
        ram_wdata = fill_val_q;
        if (fill_addr_q == LAST_ADDR) begin
          done_d  = fill_report_q;
          data_d  = '0;
          state_d = ST_IDLE;
        end else begin
          fill_addr_d = fill_addr_q + AW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_FILL;
      fill_addr_q   <= '0;
      fill_val_q    <= {RESET_ATTR, CODE_BLANK};
      fill_report_q <= 1'b0;
      src_q         <= '0;
      cp_pend_q     <= 1'b0;
      col_q         <= '0;
      line_q        <= '0;
      attr_q        <= RESET_ATTR;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      fill_addr_q   <= fill_addr_d;
      fill_val_q    <= fill_val_d;
      fill_report_q <= fill_report_d;
      src_q         <= src_d;
      cp_pend_q     <= cp_pend_d;
      col_q         <= col_d;
      line_q        <= line_d;
      attr_q        <= attr_d;
      done_q        <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_addr_q <= cp_addr_d;
    data_q    <= data_d;
    code_q    <= code_d;
    index_q   <= index_d;
  end

  assign busy            = (state_q != ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign done_o          = done_q;
  assign cell_data_o     = data_q;
  assign cursor_column_o = COL_OUT_W'(col_q);
  assign cursor_line_o   = LINE_OUT_W'(line_q);

endmodule
